@@ src/envfc_pkg.sv @@
package envfc_pkg;

    // Width of the saturating byte counter and of the length fields.
    localparam int COUNT_WIDTH   = 48;
    localparam int LENGTH_WIDTH  = 48;
    localparam int VERSION_WIDTH = 16;
    localparam int SUM_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = 48;

    localparam logic [COUNT_WIDTH-1:0] HDR_LEN   = COUNT_WIDTH'(24);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [SUM_WIDTH-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [LENGTH_WIDTH-1:0]  MAX_BYTES_RESET = 48'd16777216;
    localparam logic [VERSION_WIDTH-1:0] VERSION_RESET   = 16'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_BYTES        = 4'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROTOCOL_VERSION = 4'd1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_VERSION   = 3'd4,
        ST_INVALID   = 3'd5,
        ST_TRAILING  = 3'd6,
        ST_CHECKSUM  = 3'd7
    } status_t;

    // Everything the status decision needs once the last byte has been folded in.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0]   len;
        logic [LENGTH_WIDTH-1:0]  avail;
        logic                     magic_ok;
        logic [VERSION_WIDTH-1:0] version_word;
        logic                     reserved_nz;
        logic [SUM_WIDTH-1:0]     declared_length;
        logic [SUM_WIDTH-1:0]     expected_sum;
        logic [SUM_WIDTH-1:0]     hash;
    } envfc_snap_t;

    // Expected magic byte at header positions zero to three.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h53;
            2'd1:    b = 8'h57;
            2'd2:    b = 8'h4D;
            default: b = 8'h46;
        endcase
        return b;
    endfunction

    // One FNV-1a step. The prime is 2^40 + 2^8 + 0xB3, so the product is a
    // sum of shifted copies of the mixed value, taken modulo 2^64.
    function automatic logic [SUM_WIDTH-1:0] fnv_step(input logic [SUM_WIDTH-1:0] h,
                                                      input logic [7:0] b);
        logic [SUM_WIDTH-1:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

@@ src/envfc_parser.sv @@
module envfc_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     last,
    output envfc_pkg::envfc_snap_t   snap
);
    import envfc_pkg::*;

    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     magic_reg, magic_next;
    logic [VERSION_WIDTH-1:0] version_reg, version_next;
    logic [VERSION_WIDTH-1:0] reserved_reg, reserved_next;
    logic [SUM_WIDTH-1:0]     declared_reg, declared_next;
    logic [SUM_WIDTH-1:0]     expected_reg, expected_next;
    logic [SUM_WIDTH-1:0]     hash_reg, hash_next;
    logic [4:0]               lane;
    logic                     in_header;

    assign lane      = count_reg[4:0];
    assign in_header = (count_reg < HDR_LEN);

    // Route the byte into its header field, or fold it into the hash.
    always_comb begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        reserved_next = reserved_reg;
        declared_next = declared_reg;
        expected_next = expected_reg;
        hash_next     = hash_reg;
        if (in_header) begin
            case (lane) inside
                [5'd0:5'd3]: begin
                    if (data_byte != magic_byte(lane[1:0])) begin
                        magic_next = 1'b0;
                    end
                end
                [5'd4:5'd5]:   version_next[{lane[0], 3'b000} +: 8] = data_byte;
                [5'd6:5'd7]:   reserved_next[{lane[0], 3'b000} +: 8] = data_byte;
                [5'd8:5'd15]:  declared_next[{lane[2:0], 3'b000} +: 8] = data_byte;
                default:       expected_next[{lane[2:0], 3'b000} +: 8] = data_byte;
            endcase
        end else begin
            hash_next = fnv_step(hash_reg, data_byte);
        end
    end

    // The counter stops at all ones.
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_WIDTH'(1);

    // Values seen by the status decision when this byte is the last one.
    always_comb begin
        snap.len             = count_next;
        snap.avail           = (count_next >= HDR_LEN) ?
                               LENGTH_WIDTH'(count_next - HDR_LEN) : '0;
        snap.magic_ok        = magic_next;
        snap.version_word    = version_next;
        snap.reserved_nz     = (reserved_next != '0);
        snap.declared_length = declared_next;
        snap.expected_sum    = expected_next;
        snap.hash            = hash_next;
    end

    // Stream state; the last byte of a buffer returns it to its start values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last)) begin
            count_reg    <= '0;
            magic_reg    <= 1'b1;
            version_reg  <= '0;
            reserved_reg <= '0;
            declared_reg <= '0;
            expected_reg <= '0;
            hash_reg     <= FNV_BASIS;
        end else if (step) begin
            count_reg    <= count_next;
            magic_reg    <= magic_next;
            version_reg  <= version_next;
            reserved_reg <= reserved_next;
            declared_reg <= declared_next;
            expected_reg <= expected_next;
            hash_reg     <= hash_next;
        end
    end

endmodule

@@ src/envelope_fnv1a_frame_checker_top.sv @@
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_data_byte[7:0], s_last
// m_        out        m_valid / m_ready   m_status[2:0], m_payload_length[47:0]
// cfg_      in         cfg_valid/cfg_ready cfg_index[3:0], cfg_data[47:0]
//
// One byte is taken every cycle while no last byte is held back; the hash update of
// the byte in the input register is the longest path. A status passes from the
// input register, where its last byte is taken, through the snapshot register
// to the status register.
// Reset (aresetn low, synchronous) clears the stream and restores the registers.
// A stalled status output holds back only last bytes; other bytes keep flowing.
module envelope_fnv1a_frame_checker_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [7:0]                            s_data_byte,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_status,
    output logic [envfc_pkg::LENGTH_WIDTH-1:0]    m_payload_length,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [envfc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [envfc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import envfc_pkg::*;

    logic [LENGTH_WIDTH-1:0]  max_bytes_reg;
    logic [VERSION_WIDTH-1:0] version_cfg_reg;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    logic        snap_valid_reg;
    envfc_snap_t snap_reg;
    envfc_snap_t snap_next;

    logic                    out_valid_reg;
    status_t                 status_reg, status_next;
    logic [LENGTH_WIDTH-1:0] length_reg;

    logic out_free, snap_move, snap_free, step;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg   <= MAX_BYTES_RESET;
            version_cfg_reg <= VERSION_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_MAX_BYTES) begin
                max_bytes_reg <= cfg_data[LENGTH_WIDTH-1:0];
            end else if (cfg_index == CFG_PROTOCOL_VERSION) begin
                version_cfg_reg <= cfg_data[VERSION_WIDTH-1:0];
            end
        end
    end

    // Flow control between the three stages.
    assign out_free  = !out_valid_reg || m_ready;
    assign snap_move = snap_valid_reg && out_free;
    assign snap_free = !snap_valid_reg || snap_move;
    assign step      = in_valid_reg && (!in_last_reg || snap_free);
    assign s_ready   = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    envfc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_data_reg),
        .last      (in_last_reg),
        .snap      (snap_next)
    );

    // Snapshot of the finished buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (step && in_last_reg) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_move) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            snap_reg <= snap_next;
        end
    end

    // Ordered checks; the first one that fails sets the status.
    always_comb begin
        if ((max_bytes_reg < HDR_LEN) || (snap_reg.len > max_bytes_reg) ||
            (snap_reg.len == COUNT_MAX)) begin
            status_next = ST_LIMIT;
        end else if (snap_reg.len < HDR_LEN) begin
            status_next = ST_TRUNCATED;
        end else if (!snap_reg.magic_ok) begin
            status_next = ST_MAGIC;
        end else if (snap_reg.version_word != version_cfg_reg) begin
            status_next = ST_VERSION;
        end else if (snap_reg.reserved_nz) begin
            status_next = ST_INVALID;
        end else if (snap_reg.declared_length > SUM_WIDTH'(snap_reg.avail)) begin
            status_next = ST_TRUNCATED;
        end else if (snap_reg.declared_length < SUM_WIDTH'(snap_reg.avail)) begin
            status_next = ST_TRAILING;
        end else if (snap_reg.hash != snap_reg.expected_sum) begin
            status_next = ST_CHECKSUM;
        end else begin
            status_next = ST_OK;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (snap_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_move) begin
            status_reg <= status_next;
            length_reg <= snap_reg.avail;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_payload_length = length_reg;

endmodule

@@ src/envfc_checker.sv @@
module envfc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_last,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [2:0]                            m_status,
    input logic [envfc_pkg::LENGTH_WIDTH-1:0]    m_payload_length,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready
);
    import envfc_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       last_taken, result_taken;

    // Count buffers whose last byte has gone in but whose status has not left.
    assign last_taken   = s_valid && s_ready && s_last;
    assign result_taken = m_valid && m_ready;
    assign pending_next = pending_reg + {2'b00, last_taken} - {2'b00, result_taken};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled status holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_payload_length))
        else $error("status changed while stalled");

    // A status only ever answers a last byte that has been taken.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("status without a finished buffer");

    // At most three finished buffers can be held inside the block.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd3)
        else $error("more buffers pending than stages");

    // No status straight out of reset.
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("status shown right after reset");

    // Configuration writes are never refused.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration request refused");

endmodule

bind envelope_fnv1a_frame_checker_top envfc_checker u_envfc_checker (.*);
